// File: rtl/core/ple_pkg.sv
// shared types and constants for the positional list engine
// field widths, action and status codes, sequencer state and result types
// no dependencies
package ple_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_SHIFT_DOWN,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    len;
  } res_t;

endpackage

// File: rtl/core/positional_list_engine.sv
// positional list engine top level: element ram, request sequencer, result register
// depends on ple_pkg, ple_ram, ple_seq
//
// Holds an ordered list of up to DEPTH signed words. A request on the in channel
// (in_valid/in_ready) carries action, position (1-based) and write_value. Insert
// places write_value before position (length+1 appends), delete removes and returns
// the entry at position, get returns it. Every request gives one result on the out
// channel (out_valid/out_ready): status, read_value and the list length afterward.
// The entries live in one ram; an insert or delete moves the later entries one per
// cycle through its read and write ports. An insert or delete reads list length -
// position + 1 entries, a get reads one, and an append or a rejected request
// reads none.
// A result waits in the output register while the next request is taken; a new
// result waits in the sequencer until that register is free, stalling the in side.
// Reset empties the list; ram contents are left as they are and never read.
module positional_list_engine #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ple_pkg::ACTION_W-1:0]        action,
  input  logic [ple_pkg::POS_W-1:0]           position,
  input  logic signed [ple_pkg::VAL_W-1:0]    write_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ple_pkg::STATUS_W-1:0]        status,
  output logic signed [ple_pkg::VAL_W-1:0]    read_value,
  output logic [ple_pkg::LEN_W-1:0]           list_length
);

  localparam int AW = $clog2(DEPTH);

  logic                  out_free;
  logic                  res_load;
  ple_pkg::res_t         res;
  logic [DATA_WIDTH-1:0] res_word;
  logic [DATA_WIDTH-1:0] wr_word;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;

  assign wr_word  = DATA_WIDTH'(write_value);
  assign out_free = !out_valid || out_ready;

  ple_seq #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .position  (position),
    .wr_word   (wr_word),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .res_word  (res_word),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ple_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status      <= res.status;
      list_length <= res.len;
      read_value  <= ple_pkg::VAL_W'($signed(res_word));
    end
  end

endmodule

// File: rtl/core/ple_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/ple_seq.sv
// request sequencer: range checks, fill count and the shift loop through the ram
// depends on ple_pkg
module ple_seq #(
  parameter int DEPTH = ple_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ple_pkg::ACTION_W-1:0]  action,
  input  logic [ple_pkg::POS_W-1:0]     position,
  input  logic [DATA_WIDTH-1:0]         wr_word,
  input  logic                          out_free,
  output logic                          res_load,
  output ple_pkg::res_t                 res,
  output logic [DATA_WIDTH-1:0]         res_word,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [DATA_WIDTH-1:0]         ram_wdata,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [DATA_WIDTH-1:0]         ram_rdata
);

  localparam int CMPW = ((CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W) + 1;

  ple_pkg::seq_state_t state, state_next;

  logic [CW-1:0]         fill, fill_next;
  logic [AW-1:0]         slot, slot_c;
  logic [DATA_WIDTH-1:0] wval;
  logic [AW-1:0]         rd_ptr;
  logic [CW-1:0]         moves_left;
  logic                  pend_valid;
  logic [AW-1:0]         pend_addr;
  logic                  first;

  logic [CMPW-1:0]              pos_x, fill_x;
  logic                         ins_ok, rd_ok, full, in_acc;
  ple_pkg::seq_state_t          start_state;
  logic [ple_pkg::STATUS_W-1:0] status_c;

  // request decode against the current fill level
  always_comb begin
    pos_x  = CMPW'(position);
    fill_x = CMPW'(fill);
    ins_ok = (position != '0) && (pos_x <= fill_x + CMPW'(1));
    rd_ok  = (position != '0) && (pos_x <= fill_x);
    full   = (fill == CW'(DEPTH));
    slot_c = AW'(position - 1'b1);
    in_acc = in_valid && in_ready;
    start_state = ple_pkg::ST_DONE;
    status_c    = ple_pkg::STATUS_RANGE;
    fill_next   = fill;
    unique case (action)
      ple_pkg::ACT_INSERT: begin
        if (ins_ok && full) begin
          status_c = ple_pkg::STATUS_FULL;
        end else if (ins_ok) begin
          status_c    = ple_pkg::STATUS_OK;
          start_state = ple_pkg::ST_SHIFT_UP;
          fill_next   = fill + 1'b1;
        end
      end
      ple_pkg::ACT_DELETE: begin
        if (rd_ok) begin
          status_c    = ple_pkg::STATUS_OK;
          start_state = ple_pkg::ST_SHIFT_DOWN;
          fill_next   = fill - 1'b1;
        end
      end
      ple_pkg::ACT_GET: begin
        if (rd_ok) begin
          status_c    = ple_pkg::STATUS_OK;
          start_state = ple_pkg::ST_SHIFT_DOWN;
        end
      end
      default: begin
        status_c = ple_pkg::STATUS_RANGE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ple_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = start_state;
        end
      end
      ple_pkg::ST_SHIFT_UP, ple_pkg::ST_SHIFT_DOWN: begin
        if (moves_left == '0 && !pend_valid) begin
          state_next = ple_pkg::ST_DONE;
        end
      end
      ple_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ple_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ple_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = (state == ple_pkg::ST_IDLE);
    res_load  = (state == ple_pkg::ST_DONE) && out_free;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr;
    ram_we    = 1'b0;
    ram_waddr = pend_addr;
    ram_wdata = ram_rdata;
    unique case (state)
      ple_pkg::ST_SHIFT_UP: begin
        // reads walk down, writes trail one entry above
        ram_re = (moves_left != '0);
        ram_we = pend_valid;
        if (moves_left == '0 && !pend_valid) begin
          ram_we    = 1'b1;
          ram_waddr = slot;
          ram_wdata = wval;
        end
      end
      ple_pkg::ST_SHIFT_DOWN: begin
        // the first read is the addressed entry, later ones move down by one
        ram_re = (moves_left != '0);
        ram_we = pend_valid && !first;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ple_pkg::ST_IDLE;
      fill       <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= ram_re;
      if (in_acc) begin
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot       <= slot_c;
      wval       <= wr_word;
      first      <= 1'b1;
      res.status <= status_c;
      res.len    <= ple_pkg::LEN_W'(fill_next);
      res_word   <= '0;
      if (action == ple_pkg::ACT_INSERT) begin
        rd_ptr     <= AW'(fill - 1'b1);
        moves_left <= fill - CW'(slot_c);
      end else if (action == ple_pkg::ACT_DELETE) begin
        rd_ptr     <= slot_c;
        moves_left <= fill - CW'(slot_c);
      end else begin
        rd_ptr     <= slot_c;
        moves_left <= CW'(1);
      end
    end else begin
      if (ram_re) begin
        moves_left <= moves_left - 1'b1;
        if (state == ple_pkg::ST_SHIFT_UP) begin
          rd_ptr    <= rd_ptr - 1'b1;
          pend_addr <= rd_ptr + 1'b1;
        end else begin
          rd_ptr    <= rd_ptr + 1'b1;
          pend_addr <= rd_ptr - 1'b1;
        end
      end
      if (state == ple_pkg::ST_SHIFT_DOWN && pend_valid) begin
        first <= 1'b0;
        if (first) begin
          res_word <= ram_rdata;
        end
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill level above depth");

  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write hit the same entry during a shift");

  a_fill_only_on_request: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready) |=> $stable(fill))
    else $error("fill level changed without a request");

  a_ram_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ple_pkg::ST_IDLE || state == ple_pkg::ST_DONE) |-> (!ram_we && !ram_re))
    else $error("ram access outside a shift");

endmodule

// File: tb/positional_list_engine_tb.sv
// testbench for positional_list_engine: directed and random insert, delete and get requests
// checked against a list model kept in a small scoreboard class
// depends on ple_pkg and the positional_list_engine rtl
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ple_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int LIST_DEPTH = ple_pkg::DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [ple_pkg::STATUS_W-1:0]     status;
    logic signed [ple_pkg::VAL_W-1:0] value;
    logic [ple_pkg::LEN_W-1:0]        len;
  } list_result_t;

  class list_scoreboard;
    logic signed [ple_pkg::VAL_W-1:0] cells [LIST_DEPTH];
    int fill;
    list_result_t pending [$];
    int errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    // apply one accepted request to the list copy and queue its result
    function void note_request(logic [ple_pkg::ACTION_W-1:0] act,
                               logic [ple_pkg::POS_W-1:0] pos,
                               logic signed [ple_pkg::VAL_W-1:0] val);
      list_result_t r;
      int slot;
      int k;
      r.status = ple_pkg::STATUS_RANGE;
      r.value = '0;
      slot = int'(pos) - 1;
      case (act)
        ple_pkg::ACT_INSERT: begin
          if (pos >= 1 && int'(pos) <= fill + 1) begin
            if (fill >= LIST_DEPTH) begin
              r.status = ple_pkg::STATUS_FULL;
            end else begin
              for (k = fill; k > slot; k--) cells[k] = cells[k-1];
              cells[slot] = val;
              fill++;
              r.status = ple_pkg::STATUS_OK;
            end
          end
        end
        ple_pkg::ACT_DELETE: begin
          if (pos >= 1 && int'(pos) <= fill) begin
            r.value = cells[slot];
            for (k = slot; k + 1 < fill; k++) cells[k] = cells[k+1];
            fill--;
            r.status = ple_pkg::STATUS_OK;
          end
        end
        ple_pkg::ACT_GET: begin
          if (pos >= 1 && int'(pos) <= fill) begin
            r.value = cells[slot];
            r.status = ple_pkg::STATUS_OK;
          end
        end
        default: ;
      endcase
      r.len = fill[ple_pkg::LEN_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [ple_pkg::STATUS_W-1:0] st,
                               logic signed [ple_pkg::VAL_W-1:0] val,
                               logic [ple_pkg::LEN_W-1:0] len);
      list_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with no request waiting, status %0d value %0d length %0d",
                 $time, st, val, len);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, st);
        errors++;
      end
      if (val !== e.value) begin
        $display("%0t: read_value mismatch, expected %0d, got %0d", $time, e.value, val);
        errors++;
      end
      if (len !== e.len) begin
        $display("%0t: list_length mismatch, expected %0d, got %0d", $time, e.len, len);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ple_pkg::ACTION_W-1:0] action = ple_pkg::ACT_GET;
  logic [ple_pkg::POS_W-1:0] position = '0;
  logic signed [ple_pkg::VAL_W-1:0] write_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ple_pkg::STATUS_W-1:0] status;
  logic signed [ple_pkg::VAL_W-1:0] read_value;
  logic [ple_pkg::LEN_W-1:0] list_length;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  list_scoreboard sb = new();

  positional_list_engine DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .position(position),
    .write_value(write_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .read_value(read_value),
    .list_length(list_length)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: check on handshake, then pick next ready
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(status, read_value, list_length);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_request(input logic [ple_pkg::ACTION_W-1:0] act,
                              input logic [ple_pkg::POS_W-1:0] pos,
                              input logic signed [ple_pkg::VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    position <= pos;
    write_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(act, pos, val);
  endtask

  function automatic logic [ple_pkg::POS_W-1:0] pick_position(
      logic [ple_pkg::ACTION_W-1:0] act);
    int top;
    int r;
    top = (act == ple_pkg::ACT_INSERT) ? sb.fill + 1 : sb.fill;
    r = $urandom_range(99);
    if (r < 8 || top == 0) return ple_pkg::POS_W'($urandom_range(127));
    if (r < 18) return ple_pkg::POS_W'(1);
    if (r < 30) return ple_pkg::POS_W'(top);
    return ple_pkg::POS_W'($urandom_range(top, 1));
  endfunction

  function automatic logic signed [ple_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(39))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // insert_pct steers the list toward full or empty
  task automatic run_mix(input int count, input int insert_pct);
    logic [ple_pkg::ACTION_W-1:0] act;
    int i;
    for (i = 0; i < count; i++) begin
      if ($urandom_range(99) < insert_pct) act = ple_pkg::ACT_INSERT;
      else if ($urandom_range(99) < 4) act = ACT_UNUSED;
      else if ($urandom_range(1) == 0) act = ple_pkg::ACT_DELETE;
      else act = ple_pkg::ACT_GET;
      send_request(act, pick_position(act), pick_value());
    end
  endtask

  initial begin
    int p;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty list edges
    send_request(ple_pkg::ACT_GET, 7'd1, 32'sd5);
    send_request(ple_pkg::ACT_DELETE, 7'd1, 32'sd5);
    send_request(ple_pkg::ACT_INSERT, 7'd0, 32'sd9);
    send_request(ple_pkg::ACT_INSERT, 7'd2, 32'sd9);
    // build front, append and middle
    send_request(ple_pkg::ACT_INSERT, 7'd1, 32'sh7fff_ffff);
    send_request(ple_pkg::ACT_INSERT, 7'd1, 32'sh8000_0000);
    send_request(ple_pkg::ACT_INSERT, 7'd3, -32'sd1);
    send_request(ple_pkg::ACT_INSERT, 7'd2, 32'sd0);
    send_request(ple_pkg::ACT_INSERT, 7'd6, 32'sd3);
    send_request(ple_pkg::ACT_GET, 7'd1, 32'sd0);
    send_request(ple_pkg::ACT_GET, 7'd2, 32'sd0);
    send_request(ple_pkg::ACT_GET, 7'd3, 32'sd0);
    send_request(ple_pkg::ACT_GET, 7'd4, 32'sd0);
    send_request(ple_pkg::ACT_GET, 7'd5, 32'sd0);
    send_request(ple_pkg::ACT_GET, 7'd0, 32'sd0);
    send_request(ple_pkg::ACT_GET, 7'd127, 32'sd0);
    send_request(ACT_UNUSED, 7'd1, -32'sd1);
    send_request(ple_pkg::ACT_DELETE, 7'd2, 32'sd0);
    send_request(ple_pkg::ACT_DELETE, 7'd3, 32'sd0);
    send_request(ple_pkg::ACT_DELETE, 7'd0, 32'sd0);
    send_request(ple_pkg::ACT_DELETE, 7'd4, 32'sd0);
    send_request(ple_pkg::ACT_DELETE, 7'd127, 32'sd0);
    send_request(ple_pkg::ACT_INSERT, 7'd127, 32'sd1);
    send_request(ple_pkg::ACT_DELETE, 7'd1, 32'sd0);

    // each idling phase fills past full, churns, then drains back down
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 50; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 50; end
        default: begin send_idle_pct <= 14; recv_stall_pct <= 14; end
      endcase
      run_mix(110, 85);
      run_mix(100, 45);
      run_mix(115, 15);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: positional_list_engine.f
rtl/core/ple_pkg.sv
rtl/core/ple_ram.sv
rtl/core/ple_seq.sv
rtl/core/positional_list_engine.sv
tb/positional_list_engine_tb.sv
